[hdl/adpcm_b_decoder_mixer_top_defines.svh]
// Assertion macros shared by the checker of the ADPCM-B decoder and mixer.
// The macros assume a clock named clk_i and an active-low reset named rst_ni in scope.
`ifndef ADPCM_B_DECODER_MIXER_TOP_DEFINES_SVH
`define ADPCM_B_DECODER_MIXER_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ABDM_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("abdm check failed (same cycle)");

// Consequent must hold in the cycle after the antecedent.
`define ABDM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("abdm check failed (next cycle)");

`endif

[hdl/abdm_pkg.sv]
// Package of the ADPCM-B decoder and mixer: microcode types, control and status
// structs, decoder constants and saturation helpers. Depends on nothing.
package abdm_pkg;

  localparam int unsigned PcW = 3;

  localparam logic [14:0] StepMin     = 15'd127;
  localparam logic [14:0] StepMax     = 15'd24576;
  localparam logic [15:0] VolumeReset = 16'd256;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_DELTA,
    OP_UPDATE,
    OP_SCALE,
    OP_MIX
  } abdm_op_e;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_IN,
    STALL_OUT
  } abdm_stall_e;

  typedef enum logic [1:0] {
    BR_NEXT,
    BR_LOOP,
    BR_JUMP
  } abdm_br_e;

  typedef struct packed {
    abdm_op_e         op;
    abdm_stall_e      stall;
    abdm_br_e         br;
    logic [PcW-1:0]   target;
  } abdm_uword_t;

  typedef struct packed {
    abdm_op_e op;
    logic     exec;
    logic     in_ready;
  } abdm_ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic out_busy;
    logic nib_lo;
  } abdm_stat_t;

  // Step size rescale factors in 1/64 units, indexed by nibble magnitude.
  function automatic logic [7:0] step_mult(input logic [2:0] mag);
    logic [7:0] m;
    case (mag)
      3'd4:    m = 8'd77;
      3'd5:    m = 8'd102;
      3'd6:    m = 8'd128;
      3'd7:    m = 8'd153;
      default: m = 8'd57;
    endcase
    return m;
  endfunction

  function automatic logic [15:0] sat16(input logic signed [25:0] v);
    logic [15:0] r;
    if (v > 26'sd32767) begin
      r = 16'h7fff;
    end else if (v < -26'sd32768) begin
      r = 16'h8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

[hdl/abdm_sequencer.sv]
// Microcode sequencer of the ADPCM-B decoder and mixer: step counter, program
// ROM and stall/branch logic. Depends on abdm_pkg.
module abdm_sequencer (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  abdm_pkg::abdm_stat_t   stat_i,
  output abdm_pkg::abdm_ctrl_t   ctrl_o
);

  logic [abdm_pkg::PcW-1:0] pc_q, pc_d;
  abdm_pkg::abdm_uword_t    uw;
  logic                     stall;

  // Program: wait for a byte, then per nibble compute delta and new step,
  // update the predictor, apply volume and mix. The mix step loops back once.
  always_comb begin
    case (pc_q)
      3'd0:    uw = '{abdm_pkg::OP_LOAD,   abdm_pkg::STALL_IN,   abdm_pkg::BR_NEXT, 3'd0};
      3'd1:    uw = '{abdm_pkg::OP_DELTA,  abdm_pkg::STALL_NONE, abdm_pkg::BR_NEXT, 3'd0};
      3'd2:    uw = '{abdm_pkg::OP_UPDATE, abdm_pkg::STALL_NONE, abdm_pkg::BR_NEXT, 3'd0};
      3'd3:    uw = '{abdm_pkg::OP_SCALE,  abdm_pkg::STALL_NONE, abdm_pkg::BR_NEXT, 3'd0};
      3'd4:    uw = '{abdm_pkg::OP_MIX,    abdm_pkg::STALL_OUT,  abdm_pkg::BR_LOOP, 3'd1};
      default: uw = '{abdm_pkg::OP_NOP,    abdm_pkg::STALL_NONE, abdm_pkg::BR_JUMP, 3'd0};
    endcase
  end

  always_comb begin
    stall = ((uw.stall == abdm_pkg::STALL_IN) && !stat_i.in_valid) ||
            ((uw.stall == abdm_pkg::STALL_OUT) && stat_i.out_busy);
    pc_d = pc_q;
    if (!stall) begin
      case (uw.br)
        abdm_pkg::BR_LOOP: pc_d = stat_i.nib_lo ? '0 : uw.target;
        abdm_pkg::BR_JUMP: pc_d = uw.target;
        default:           pc_d = pc_q + 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= '0;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign ctrl_o.op       = uw.op;
  assign ctrl_o.exec     = !stall;
  assign ctrl_o.in_ready = (uw.stall == abdm_pkg::STALL_IN);

endmodule

[hdl/abdm_datapath.sv]
// Datapath of the ADPCM-B decoder and mixer: predictor, step size, volume,
// the shared multipliers and the output register. Depends on abdm_pkg.
module abdm_datapath (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  abdm_pkg::abdm_ctrl_t   ctrl_i,
  output abdm_pkg::abdm_stat_t   stat_o,
  input  logic                   in_valid_i,
  input  logic [7:0]             data_byte_i,
  input  logic signed [15:0]     mix_first_i,
  input  logic signed [15:0]     mix_second_i,
  input  logic                   restart_i,
  input  logic                   cfg_valid_i,
  input  logic [15:0]            cfg_volume_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic signed [15:0]     mixed_sample_o,
  output logic                   last_o
);

  logic [7:0]         byte_q;
  logic signed [15:0] mix0_q, mix1_q;
  logic signed [15:0] pred_q;
  logic [14:0]        step_q;
  logic [15:0]        volume_q;
  logic [15:0]        delta_q;
  logic [15:0]        nstep_q;
  logic signed [32:0] prod_q;
  logic               nib_lo_q;
  logic               out_valid_q;
  logic [15:0]        out_sample_q;
  logic               out_last_q;

  logic [3:0]         nib;
  logic [18:0]        dprod;
  logic [22:0]        sprod;
  logic signed [17:0] upd_sum;
  logic [14:0]        step_clamped;
  logic signed [32:0] vprod;
  logic signed [24:0] scaled;
  logic signed [15:0] mix_sel;
  logic signed [25:0] mix_sum;
  logic               do_op;

  assign nib = nib_lo_q ? byte_q[3:0] : byte_q[7:4];

  // Delta is (2*mag+1)*step/8; the new step is step*mult/64 before clamping.
  assign dprod = 19'({nib[2:0], 1'b1}) * 19'(step_q);
  assign sprod = 23'(abdm_pkg::step_mult(nib[2:0])) * 23'(step_q);

  assign upd_sum = nib[3] ? ({{2{pred_q[15]}}, pred_q} - $signed({2'b00, delta_q}))
                          : ({{2{pred_q[15]}}, pred_q} + $signed({2'b00, delta_q}));

  always_comb begin
    if (nstep_q < 16'(abdm_pkg::StepMin)) begin
      step_clamped = abdm_pkg::StepMin;
    end else if (nstep_q > 16'(abdm_pkg::StepMax)) begin
      step_clamped = abdm_pkg::StepMax;
    end else begin
      step_clamped = nstep_q[14:0];
    end
  end

  assign vprod   = $signed(pred_q) * $signed({1'b0, volume_q});
  // Arithmetic shift of the product floors toward minus infinity.
  assign scaled  = prod_q[32:8];
  assign mix_sel = nib_lo_q ? mix1_q : mix0_q;
  assign mix_sum = 26'(mix_sel) + 26'(scaled);

  assign do_op = ctrl_i.exec;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pred_q      <= '0;
      step_q      <= abdm_pkg::StepMin;
      volume_q    <= abdm_pkg::VolumeReset;
      nib_lo_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        volume_q <= cfg_volume_i;
      end
      // A new result may be loaded in the cycle in which the waiting one is taken.
      if (do_op && (ctrl_i.op == abdm_pkg::OP_MIX)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (do_op) begin
        case (ctrl_i.op)
          abdm_pkg::OP_LOAD: begin
            nib_lo_q <= 1'b0;
            if (restart_i) begin
              pred_q <= '0;
              step_q <= abdm_pkg::StepMin;
            end
          end
          abdm_pkg::OP_UPDATE: begin
            pred_q <= abdm_pkg::sat16(26'(upd_sum));
            step_q <= step_clamped;
          end
          abdm_pkg::OP_MIX: begin
            nib_lo_q <= !nib_lo_q;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (do_op) begin
      case (ctrl_i.op)
        abdm_pkg::OP_LOAD: begin
          byte_q <= data_byte_i;
          mix0_q <= mix_first_i;
          mix1_q <= mix_second_i;
        end
        abdm_pkg::OP_DELTA: begin
          delta_q <= dprod[18:3];
          nstep_q <= sprod[21:6];
        end
        abdm_pkg::OP_SCALE: begin
          prod_q <= vprod;
        end
        abdm_pkg::OP_MIX: begin
          out_sample_q <= abdm_pkg::sat16(mix_sum);
          out_last_q   <= nib_lo_q;
        end
        default: begin
        end
      endcase
    end
  end

  assign stat_o.in_valid = in_valid_i;
  assign stat_o.out_busy = out_valid_q && !out_ready_i;
  assign stat_o.nib_lo   = nib_lo_q;

  assign out_valid_o    = out_valid_q;
  assign mixed_sample_o = out_sample_q;
  assign last_o         = out_last_q;

endmodule

[hdl/adpcm_b_decoder_mixer_top.sv]
// ADPCM-B decoder and mixer. Each accepted byte yields two mixed samples, the
// high nibble first and the second one flagged by last_o. Control is a five-step
// microprogram over one shared datapath: a load step takes the byte, then each
// nibble runs delta and step products, predictor and step update, volume product,
// mix and saturate, in that order; a stalled result holds the program at its mix
// step. The output register lets a result wait while work goes on.
// The volume register (Q8, reset 256) is written through the cfg channel, which
// is always ready and should only be used while the block is idle.
// Depends on abdm_pkg, abdm_sequencer and abdm_datapath.
module adpcm_b_decoder_mixer_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [15:0]        cfg_volume_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         data_byte_i,
  input  logic signed [15:0] mix_first_i,
  input  logic signed [15:0] mix_second_i,
  input  logic               restart_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] mixed_sample_o,
  output logic               last_o
);

  abdm_pkg::abdm_ctrl_t ctrl;
  abdm_pkg::abdm_stat_t stat;

  abdm_sequencer u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  abdm_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .stat_o         (stat),
    .in_valid_i     (in_valid_i),
    .data_byte_i    (data_byte_i),
    .mix_first_i    (mix_first_i),
    .mix_second_i   (mix_second_i),
    .restart_i      (restart_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_volume_i   (cfg_volume_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .mixed_sample_o (mixed_sample_o),
    .last_o         (last_o)
  );

  assign in_ready_o  = ctrl.in_ready;
  assign cfg_ready_o = 1'b1;

endmodule

[hdl/abdm_checker.sv]
// Port-level checker of the ADPCM-B decoder and mixer, bound to the top level.
// Depends on adpcm_b_decoder_mixer_top_defines.svh.
`include "adpcm_b_decoder_mixer_top_defines.svh"

module abdm_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               cfg_valid_i,
  input logic               cfg_ready_o,
  input logic [15:0]        cfg_volume_i,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic [7:0]         data_byte_i,
  input logic signed [15:0] mix_first_i,
  input logic signed [15:0] mix_second_i,
  input logic               restart_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [15:0] mixed_sample_o,
  input logic               last_o
);

  // A byte transfer starts decoding, so the input side closes right away.
  `ABDM_ASSERT_NEXT(a_busy_after_in, in_valid_i && in_ready_o, !in_ready_o)

  // While a first result is pending, the second is still to come.
  `ABDM_ASSERT_SAME(a_no_in_mid_pair, out_valid_o && !last_o, !in_ready_o)

  // After the first result of a pair is taken, the next one shown is the second.
  `ABDM_ASSERT_NEXT(a_pair_continues, out_valid_o && out_ready_i && !last_o,
                    !out_valid_o || last_o)

  // A stalled result holds its value.
  `ABDM_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i,
                    out_valid_o && $stable(mixed_sample_o) && $stable(last_o))

endmodule

bind adpcm_b_decoder_mixer_top abdm_checker u_abdm_checker (.*);

[tb/adpcm_b_decoder_mixer_checker.sv]
// Scoreboard for the ADPCM-B decoder and mixer: watches the config, input and output
// channels, predicts both mixed samples of every accepted byte and compares them.
// Depends on abdm_pkg for the step size bounds and the volume reset value.
module adpcm_b_decoder_mixer_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [15:0] cfg_volume_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  data_byte_i,
  input  logic [15:0] mix_first_i,
  input  logic [15:0] mix_second_i,
  input  logic        restart_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [15:0] mixed_sample_i,
  input  logic        last_i,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [15:0] sample;
    logic        last;
  } mixed_result_t;

  logic signed [15:0] pred_q;
  logic [14:0]        step_q;
  logic [15:0]        vol_q;
  mixed_result_t      mixed_expected_q[$];
  int                 reported;

  function automatic int unsigned rescale_factor(input logic [2:0] mag);
    int unsigned f;
    case (mag)
      3'd4:    f = 77;
      3'd5:    f = 102;
      3'd6:    f = 128;
      3'd7:    f = 153;
      default: f = 57;
    endcase
    return f;
  endfunction

  // Decodes one nibble and advances the predictor and step size.
  function automatic logic signed [15:0] next_sample(input logic [3:0] nib);
    int unsigned mag_w;
    int unsigned new_step;
    int          delta;
    int          sum;
    mag_w    = nib[2:0];
    delta    = int'(((2 * mag_w + 1) * step_q) >> 3);
    sum      = nib[3] ? int'(pred_q) - delta : int'(pred_q) + delta;
    new_step = (rescale_factor(nib[2:0]) * step_q) >> 6;
    if (new_step < abdm_pkg::StepMin) new_step = abdm_pkg::StepMin;
    if (new_step > abdm_pkg::StepMax) new_step = abdm_pkg::StepMax;
    step_q = new_step[14:0];
    if (sum > 32767) begin
      pred_q = 16'sh7fff;
    end else if (sum < -32768) begin
      pred_q = 16'sh8000;
    end else begin
      pred_q = sum[15:0];
    end
    return pred_q;
  endfunction

  // The arithmetic shift of the full-width product rounds toward minus infinity.
  function automatic logic [15:0] scale_and_mix(input logic signed [15:0] sample,
                                                input logic signed [15:0] mix);
    longint prod;
    longint total;
    prod  = longint'(sample) * longint'(vol_q);
    total = longint'(mix) + (prod >>> 8);
    if (total > 32767) total = 32767;
    if (total < -32768) total = -32768;
    return total[15:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    mixed_result_t      got;
    mixed_result_t      want;
    logic signed [15:0] s;
    if (!rst_ni) begin
      pred_q       = 16'sd0;
      step_q       = abdm_pkg::StepMin;
      vol_q        = abdm_pkg::VolumeReset;
      fail_count_o = 0;
      reported     = 0;
      mixed_expected_q.delete();
      pending_o    = 0;
    end else begin
      // Results leaving the block always belong to older bytes, so compare first.
      if (out_valid_i && out_ready_i) begin
        got = '{sample: mixed_sample_i, last: last_i};
        if (mixed_expected_q.size() == 0) begin
          fail_count_o++;
          if (reported < 10) begin
            reported++;
            $display("unexpected result: sample %0d last %0b",
                     $signed(got.sample), got.last);
          end
        end else begin
          want = mixed_expected_q.pop_front();
          if (got != want) begin
            fail_count_o++;
            if (reported < 10) begin
              reported++;
              $display("mismatch: expected sample %0d last %0b, got sample %0d last %0b",
                       $signed(want.sample), want.last, $signed(got.sample), got.last);
            end
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        vol_q = cfg_volume_i;
      end
      if (in_valid_i && in_ready_i) begin
        if (restart_i) begin
          pred_q = 16'sd0;
          step_q = abdm_pkg::StepMin;
        end
        s = next_sample(data_byte_i[7:4]);
        mixed_expected_q.push_back('{sample: scale_and_mix(s, mix_first_i), last: 1'b0});
        s = next_sample(data_byte_i[3:0]);
        mixed_expected_q.push_back('{sample: scale_and_mix(s, mix_second_i), last: 1'b1});
      end
      pending_o = mixed_expected_q.size();
    end
  end

endmodule

[tb/tb_top.sv]
// Top of the ADPCM-B decoder and mixer testbench: clock, reset, stimulus, idling and
// the verdict. Instantiates adpcm_b_decoder_mixer_top and adpcm_b_decoder_mixer_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int StallLimit = 1000;
  localparam int SettleCycles = 20;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [15:0]        cfg_volume_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [7:0]         data_byte_i;
  logic signed [15:0] mix_first_i;
  logic signed [15:0] mix_second_i;
  logic               restart_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic signed [15:0] mixed_sample_o;
  logic               last_o;

  int fail_count;
  int pending;
  int idle_pct;
  int stall_pct;
  int quiet_cycles;

  adpcm_b_decoder_mixer_top u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_volume_i   (cfg_volume_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .mix_first_i    (mix_first_i),
    .mix_second_i   (mix_second_i),
    .restart_i      (restart_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .mixed_sample_o (mixed_sample_o),
    .last_o         (last_o)
  );

  adpcm_b_decoder_mixer_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_i    (cfg_ready_o),
    .cfg_volume_i   (cfg_volume_i),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .mix_first_i    (mix_first_i),
    .mix_second_i   (mix_second_i),
    .restart_i      (restart_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .mixed_sample_i (mixed_sample_o),
    .last_i         (last_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  always #1 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  // Any cycle without a transfer on any channel counts toward the timeout.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else if ((cfg_valid_i && cfg_ready_o) || (in_valid_i && in_ready_o) ||
                 (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("tb_top failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Called and returns at a falling edge; valid stays high after the transfer.
  task automatic send_byte(input logic [7:0] data, input logic [15:0] mix0,
                           input logic [15:0] mix1, input logic rs);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    data_byte_i  <= data;
    mix_first_i  <= mix0;
    mix_second_i <= mix1;
    restart_i    <= rs;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic write_volume(input logic [15:0] vol);
    drain_results();
    repeat (SettleCycles) @(negedge clk_i);
    cfg_valid_i  <= 1'b1;
    cfg_volume_i <= vol;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    logic [15:0] vols[8];
    logic [7:0]  data;
    logic [15:0] mix0;
    logic [15:0] mix1;
    int          kind;
    clk_i        = 1'b0;
    rst_ni       = 1'b0;
    cfg_valid_i  = 1'b0;
    cfg_volume_i = 16'd0;
    in_valid_i   = 1'b0;
    data_byte_i  = 8'd0;
    mix_first_i  = 16'sd0;
    mix_second_i = 16'sd0;
    restart_i    = 1'b0;
    out_ready_i  = 1'b0;
    idle_pct     = 0;
    stall_pct    = 0;
    vols = '{16'd0, 16'hffff, 16'd1, 16'($urandom), 16'd256, 16'($urandom),
             16'd128, 16'h8000};
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Unity gain from reset: drive the step size to its top and the predictor
    // into saturation in both directions, with the mix extremes on top.
    send_byte(8'h00, 16'sd0, 16'sd0, 1'b1);
    repeat (6) send_byte(8'h77, 16'h7fff, 16'h8000, 1'b0);
    repeat (5) send_byte(8'hff, 16'h8000, 16'h7fff, 1'b0);
    send_byte(8'h08, 16'sd0, 16'sd0, 1'b0);
    send_byte(8'h80, 16'sd0, 16'sd0, 1'b0);
    send_byte(8'h3c, 16'h1234, 16'hedcb, 1'b1);
    send_byte(8'h5a, 16'sd0, 16'sd0, 1'b0);

    // Largest gain: the scaled sample exceeds 16 bits and negative products floor.
    write_volume(16'hffff);
    send_byte(8'h11, 16'sd0, 16'sd0, 1'b1);
    repeat (2) send_byte(8'h77, 16'sd0, 16'sd0, 1'b0);
    repeat (3) send_byte(8'hff, 16'sd0, 16'sd0, 1'b0);
    send_byte(8'h9a, 16'h8000, 16'h7fff, 1'b1);

    for (int p = 0; p < 8; p++) begin
      write_volume(vols[p]);
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 55; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 55; end
        default: begin idle_pct = 9; stall_pct = 9; end
      endcase
      for (int i = 0; i < 104; i++) begin
        kind = $urandom_range(99);
        if (kind < 6) begin
          data = 8'h77;
        end else if (kind < 12) begin
          data = 8'hff;
        end else if (kind < 18) begin
          data = 8'h00;
        end else begin
          data = 8'($urandom);
        end
        mix0 = ($urandom_range(9) == 0) ? ($urandom_range(1) ? 16'h7fff : 16'h8000)
                                        : 16'($urandom);
        mix1 = ($urandom_range(9) == 0) ? ($urandom_range(1) ? 16'h7fff : 16'h8000)
                                        : 16'($urandom);
        send_byte(data, mix0, mix1, ($urandom_range(99) < 4));
        if (i == 50) drain_results();
      end
    end

    drain_results();
    repeat (SettleCycles) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
